/* src/largest_balanced_binary_submatrix_unit_defines.svh */
// assertion macros for the largest balanced binary submatrix unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef LARGEST_BALANCED_BINARY_SUBMATRIX_UNIT_DEFINES_SVH
`define LARGEST_BALANCED_BINARY_SUBMATRIX_UNIT_DEFINES_SVH

// same-cycle implication
`define LBBS_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define LBBS_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

/* src/lbbs_pkg.sv */
// sizes, widths and constants of the largest balanced binary submatrix unit
// no dependencies
package lbbs_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int BAL_W  = $clog2(MAX_COLS + 1) + 1;
    localparam int SUM_W  = $clog2(CELLS + 1) + 1;
    localparam int SPAN   = 2 * CELLS + 1;
    localparam int SLOT_W = $clog2(SPAN);
    localparam int AREA_W = $clog2(CELLS + 1);
    localparam int TAB_W  = ROW_W + 1;

    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_OUT_W  = 4;
    localparam int AREA_OUT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IDX = 2'd1;
    localparam logic [CFG_W-1:0]     SIZE_RESET   = 5'd16;

    localparam logic signed [BAL_W-1:0] BAL_POS_ONE = BAL_W'(1);
    localparam logic signed [BAL_W-1:0] BAL_NEG_ONE = BAL_W'(-1);

endpackage

/* src/largest_balanced_binary_submatrix_unit.sv */
// largest balanced binary submatrix unit: loads a binary matrix and searches it
// depends on lbbs_pkg and largest_balanced_binary_submatrix_unit_defines.svh
//
// usage:
// - input channel i_valid/o_ready carries one cell word (i_cell_value) per
//   handshake, row-major; one word is taken per cycle while loading
// - config port i_cfg_we/i_cfg_idx/i_cfg_data sets rows (index 0) and
//   columns (index 1); a write to either restarts the load
// - the word that completes rows*cols cells starts the search; o_ready is
//   low until it ends
// - the search walks every column pair (left <= right); each pair runs a
//   pair step, then per row a balance step and a prefix-table lookup and
//   update step, then a table clear step per row, then an area step; the
//   best area is kept over all pairs
// - one result word then sits on o_valid until i_ready; the next matrix may
//   load meanwhile, but its last cell waits while the result is still held
// - after reset the 2*rows_max*cols_max+1 = 513 prefix table entries are
//   cleared with o_ready low; config writes are taken during that time
`include "largest_balanced_binary_submatrix_unit_defines.svh"

module largest_balanced_binary_submatrix_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbbs_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_cell_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_found,
    output logic [lbbs_pkg::ROW_OUT_W-1:0]   o_top_row,
    output logic [lbbs_pkg::ROW_OUT_W-1:0]   o_bottom_row,
    output logic [lbbs_pkg::ROW_OUT_W-1:0]   o_left_col,
    output logic [lbbs_pkg::ROW_OUT_W-1:0]   o_right_col,
    output logic [lbbs_pkg::AREA_OUT_W-1:0]  o_area
);
    import lbbs_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_LOAD, S_PAIR, S_ROW_A, S_ROW_B, S_CLR, S_AREA, S_DONE
    } t_state;

    function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [RCNT_W-1:0] r;
        if (v == '0) r = RCNT_W'(1);
        else if (v > MAX_ROWS) r = RCNT_W'(MAX_ROWS);
        else r = RCNT_W'(v);
        return r;
    endfunction

    function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [CCNT_W-1:0] r;
        if (v == '0) r = CCNT_W'(1);
        else if (v > MAX_COLS) r = CCNT_W'(MAX_COLS);
        else r = CCNT_W'(v);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] u;
        u = SUM_W'(unsigned'(s) + SUM_W'(CELLS));
        return SLOT_W'(u);
    endfunction

    // memories
    logic             r_cells [CELLS];
    logic [TAB_W-1:0] r_tab   [SPAN];
    logic             r_cell_q;
    logic [TAB_W-1:0] r_tab_q;

    // control and datapath registers
    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_rows_cfg, n_rows_cfg;
    logic [CFG_W-1:0]         r_cols_cfg, n_cols_cfg;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [SLOT_W-1:0]        r_init_addr, n_init_addr;
    logic [COL_W-1:0]         r_left, n_left;
    logic [COL_W-1:0]         r_right, n_right;
    logic [ROW_W-1:0]         r_row, n_row;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [RCNT_W-1:0]        r_len, n_len;
    logic [ROW_W-1:0]         r_s, n_s;
    logic [ROW_W-1:0]         r_e, n_e;
    logic signed [BAL_W-1:0]  r_bal [MAX_ROWS];
    logic signed [BAL_W-1:0]  n_bal [MAX_ROWS];
    logic [AREA_W-1:0]        r_best_area, n_best_area;
    logic [ROW_W-1:0]         r_best_top, n_best_top;
    logic [ROW_W-1:0]         r_best_bot, n_best_bot;
    logic [COL_W-1:0]         r_best_lc, n_best_lc;
    logic [COL_W-1:0]         r_best_rc, n_best_rc;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_found, n_out_found;
    logic [ROW_OUT_W-1:0]     r_out_top, n_out_top;
    logic [ROW_OUT_W-1:0]     r_out_bot, n_out_bot;
    logic [ROW_OUT_W-1:0]     r_out_lc, n_out_lc;
    logic [ROW_OUT_W-1:0]     r_out_rc, n_out_rc;
    logic [AREA_OUT_W-1:0]    r_out_area, n_out_area;

    // memory ports
    logic                     cell_we, cell_re;
    logic [ADDR_W-1:0]        cell_waddr, cell_raddr;
    logic                     tab_we, tab_re;
    logic [SLOT_W-1:0]        tab_waddr, tab_raddr;
    logic [TAB_W-1:0]         tab_wdata;

    // shared datapath
    logic [RCNT_W-1:0]        rows;
    logic [CCNT_W-1:0]        cols;
    logic [POS_W-1:0]         total, eff_pos, pos_inc;
    logic                     is_last, last_row, accept;
    logic [ROW_W-1:0]         rd_row;
    logic signed [BAL_W-1:0]  bal_new;
    logic signed [SUM_W-1:0]  sum_a, sum_c;
    logic [ROW_W-1:0]         row_gap;
    logic [CCNT_W-1:0]        width;
    logic [AREA_W-1:0]        area_cur;

    always_comb begin
        rows     = clamp_rows(r_rows_cfg);
        cols     = clamp_cols(r_cols_cfg);
        total    = POS_W'(rows) * POS_W'(cols);
        eff_pos  = (r_pos >= total) ? '0 : r_pos;
        pos_inc  = POS_W'(eff_pos + 1'b1);
        is_last  = (pos_inc == total);
        o_ready  = (r_state == S_LOAD) && !(r_out_valid && is_last);
        accept   = i_valid && o_ready;
        last_row = (r_row == ROW_W'(rows - 1'b1));
        rd_row   = (r_state == S_ROW_A) ? ROW_W'(r_row + 1'b1) : r_row;
        bal_new  = r_bal[r_row] + (r_cell_q ? BAL_POS_ONE : BAL_NEG_ONE);
        sum_a    = r_sum + SUM_W'(bal_new);
        sum_c    = r_sum + SUM_W'(r_bal[r_row]);
        row_gap  = r_row - r_tab_q[ROW_W-1:0];
        width    = CCNT_W'(r_right - r_left) + 1'b1;
        area_cur = AREA_W'(width) * AREA_W'(r_len);
    end

    always_comb begin
        n_state     = r_state;
        n_rows_cfg  = r_rows_cfg;
        n_cols_cfg  = r_cols_cfg;
        n_pos       = r_pos;
        n_init_addr = r_init_addr;
        n_left      = r_left;
        n_right     = r_right;
        n_row       = r_row;
        n_sum       = r_sum;
        n_len       = r_len;
        n_s         = r_s;
        n_e         = r_e;
        n_bal       = r_bal;
        n_best_area = r_best_area;
        n_best_top  = r_best_top;
        n_best_bot  = r_best_bot;
        n_best_lc   = r_best_lc;
        n_best_rc   = r_best_rc;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_top   = r_out_top;
        n_out_bot   = r_out_bot;
        n_out_lc    = r_out_lc;
        n_out_rc    = r_out_rc;
        n_out_area  = r_out_area;

        cell_we    = 1'b0;
        cell_waddr = eff_pos[ADDR_W-1:0];
        cell_re    = 1'b0;
        cell_raddr = ADDR_W'(rd_row) * ADDR_W'(cols) + ADDR_W'(r_right);
        tab_we     = 1'b0;
        tab_waddr  = r_init_addr;
        tab_wdata  = '0;
        tab_re     = 1'b0;
        tab_raddr  = slot_of(sum_a);

        unique case (r_state)
            S_INIT: begin
                tab_we      = 1'b1;
                n_init_addr = SLOT_W'(r_init_addr + 1'b1);
                if (r_init_addr == SLOT_W'(SPAN - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (accept) begin
                    cell_we = 1'b1;
                    if (is_last) begin
                        n_pos       = '0;
                        n_left      = '0;
                        n_right     = '0;
                        n_row       = '0;
                        n_best_area = '0;
                        n_best_top  = '0;
                        n_best_bot  = '0;
                        n_best_lc   = '0;
                        n_best_rc   = '0;
                        for (int k = 0; k < MAX_ROWS; k++) n_bal[k] = '0;
                        n_state     = S_PAIR;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end
            S_PAIR: begin
                cell_re = 1'b1;
                n_sum   = '0;
                n_len   = '0;
                n_s     = '0;
                n_e     = '0;
                n_state = S_ROW_A;
            end
            S_ROW_A: begin
                n_bal[r_row] = bal_new;
                n_sum        = sum_a;
                tab_re       = 1'b1;
                cell_re      = !last_row;
                n_state      = S_ROW_B;
            end
            S_ROW_B: begin
                tab_waddr = slot_of(r_sum);
                tab_wdata = {1'b1, r_row};
                if (r_sum == '0) begin
                    n_s   = '0;
                    n_e   = r_row;
                    n_len = RCNT_W'(r_row) + 1'b1;
                end else if (!r_tab_q[ROW_W]) begin
                    tab_we = 1'b1;
                end else if (RCNT_W'(row_gap) > r_len) begin
                    n_len = RCNT_W'(row_gap);
                    n_s   = ROW_W'(r_tab_q[ROW_W-1:0] + 1'b1);
                    n_e   = r_row;
                end
                if (last_row) begin
                    n_row   = '0;
                    n_sum   = '0;
                    n_state = S_CLR;
                end else begin
                    n_row   = ROW_W'(r_row + 1'b1);
                    n_state = S_ROW_A;
                end
            end
            S_CLR: begin
                // undo the table entries this column pair set
                tab_we    = 1'b1;
                tab_waddr = slot_of(sum_c);
                tab_wdata = '0;
                n_sum     = sum_c;
                if (last_row) begin
                    n_row   = '0;
                    n_state = S_AREA;
                end else begin
                    n_row = ROW_W'(r_row + 1'b1);
                end
            end
            S_AREA: begin
                if (r_len != '0 && area_cur > r_best_area) begin
                    n_best_area = area_cur;
                    n_best_top  = r_s;
                    n_best_bot  = r_e;
                    n_best_lc   = r_left;
                    n_best_rc   = r_right;
                end
                if (r_right != COL_W'(cols - 1'b1)) begin
                    n_right = COL_W'(r_right + 1'b1);
                    n_state = S_PAIR;
                end else if (r_left != COL_W'(cols - 1'b1)) begin
                    n_left  = COL_W'(r_left + 1'b1);
                    n_right = COL_W'(r_left + 1'b1);
                    for (int k = 0; k < MAX_ROWS; k++) n_bal[k] = '0;
                    n_state = S_PAIR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_found = (r_best_area != '0);
                n_out_top   = ROW_OUT_W'(r_best_top);
                n_out_bot   = ROW_OUT_W'(r_best_bot);
                n_out_lc    = ROW_OUT_W'(r_best_lc);
                n_out_rc    = ROW_OUT_W'(r_best_rc);
                n_out_area  = AREA_OUT_W'(r_best_area);
                n_state     = S_LOAD;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_IDX: begin
                    n_rows_cfg = i_cfg_data;
                    n_pos      = '0;
                end
                CFG_COLS_IDX: begin
                    n_cols_cfg = i_cfg_data;
                    n_pos      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rows_cfg  <= SIZE_RESET;
            r_cols_cfg  <= SIZE_RESET;
            r_pos       <= '0;
            r_init_addr <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_row       <= '0;
            r_sum       <= '0;
            r_len       <= '0;
            r_s         <= '0;
            r_e         <= '0;
            for (int k = 0; k < MAX_ROWS; k++) r_bal[k] <= '0;
            r_best_area <= '0;
            r_best_top  <= '0;
            r_best_bot  <= '0;
            r_best_lc   <= '0;
            r_best_rc   <= '0;
            r_out_valid <= 1'b0;
            r_out_found <= 1'b0;
            r_out_top   <= '0;
            r_out_bot   <= '0;
            r_out_lc    <= '0;
            r_out_rc    <= '0;
            r_out_area  <= '0;
        end else begin
            r_state     <= n_state;
            r_rows_cfg  <= n_rows_cfg;
            r_cols_cfg  <= n_cols_cfg;
            r_pos       <= n_pos;
            r_init_addr <= n_init_addr;
            r_left      <= n_left;
            r_right     <= n_right;
            r_row       <= n_row;
            r_sum       <= n_sum;
            r_len       <= n_len;
            r_s         <= n_s;
            r_e         <= n_e;
            r_bal       <= n_bal;
            r_best_area <= n_best_area;
            r_best_top  <= n_best_top;
            r_best_bot  <= n_best_bot;
            r_best_lc   <= n_best_lc;
            r_best_rc   <= n_best_rc;
            r_out_valid <= n_out_valid;
            r_out_found <= n_out_found;
            r_out_top   <= n_out_top;
            r_out_bot   <= n_out_bot;
            r_out_lc    <= n_out_lc;
            r_out_rc    <= n_out_rc;
            r_out_area  <= n_out_area;
        end
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cells[cell_waddr] <= i_cell_value;
        end
        if (cell_re) begin
            r_cell_q <= r_cells[cell_raddr];
        end
    end

    // first-seen prefix table, valid bit on top
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        if (tab_re) begin
            r_tab_q <= r_tab[tab_raddr];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_top_row    = r_out_top;
    assign o_bottom_row = r_out_bot;
    assign o_left_col   = r_out_lc;
    assign o_right_col  = r_out_rc;
    assign o_area       = r_out_area;

    `LBBS_ASSERT_IMP(a_rise_after_done, $rose(r_out_valid), $past(r_state == S_DONE), "result without search")
    `LBBS_ASSERT_IMP(a_found_area, r_out_valid, r_out_found == (r_out_area != '0), "found flag and area disagree")
    `LBBS_ASSERT_IMP(a_bounds_order, r_out_valid && r_out_found, (r_out_top <= r_out_bot) && (r_out_lc <= r_out_rc), "bounds out of order")
    `LBBS_ASSERT_NXT(a_search_start, r_state == S_LOAD && n_state == S_PAIR, !r_out_valid && r_pos == '0, "search started over a held result")

endmodule
